// ----- hw/rtl/gamma_power_series_unit_assert.svh -----
// Assertion macros for the gamma power series RTL.
`ifndef GAMMA_POWER_SERIES_UNIT_ASSERT_SVH
`define GAMMA_POWER_SERIES_UNIT_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define GPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gamma power series check failed");

// Checks that cons follows ante at the delay given by n.
`define GPS_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("gamma power series latency check failed");

`endif

// ----- hw/rtl/gps_pkg.sv -----
// Types, constants and a saturating add helper for the gamma power series unit.
package gps_pkg;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_ONE = 64'sh0000_0001_0000_0000;
  localparam logic [23:0] OUT_MAX = 24'hFF_FFFF;
  localparam logic [23:0] OUT_ONE = 24'h01_0000;
  localparam logic signed [15:0] EXP_RESET = 16'sd4096;
  localparam fx_t E_SAT_LIMIT = 64'sd16777216;
  localparam int MUL_LAT = 9;
  localparam int T_BITS = 32;
  localparam int Q_BITS = 24;

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(FX_MAX)) begin
      return FX_MAX;
    end else if (s < -65'(FX_MAX)) begin
      return -FX_MAX;
    end
    return s[63:0];
  endfunction

endpackage

// ----- hw/rtl/gps_mul.sv -----
// Pipelined saturating fixed point multiply with constant divide of the product.
module gps_mul
  import gps_pkg::*;
#(
  parameter int DIV = 1,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  fx_t           a,
  input  fx_t           b,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output fx_t           prod,
  output fx_t           quot,
  output logic [SW-1:0] out_side
);

  localparam int CHUNKS = 4;
  localparam int CW = 16;
  localparam int RW = 6;
  localparam int VW = CW + RW;
  localparam int PW = 2 * VW + 1;
  localparam logic [VW:0] RECIP = (VW + 1)'((64'd1 << VW) / DIV);
  localparam logic [RW-1:0] DIVW = RW'(DIV);

  logic          v1_r;
  fx_t           a1_r, b1_r;
  logic [SW-1:0] sd1_r;

  logic          v2_r;
  logic [63:0]   ma2_r, mb2_r;
  logic          n2_r;
  logic [SW-1:0] sd2_r;

  logic          v3_r;
  logic [63:0]   hh3_r, hl3_r, lh3_r;
  logic [31:0]   ll3_r;
  logic          n3_r;
  logic [SW-1:0] sd3_r;

  logic          dv_r   [0:CHUNKS];
  logic [63:0]   dacc_r [0:CHUNKS];
  logic [63:0]   dq_r   [0:CHUNKS];
  logic [RW-1:0] drem_r [0:CHUNKS];
  logic          dn_r   [0:CHUNKS];
  logic [SW-1:0] dsd_r  [0:CHUNKS];

  logic          v9_r;
  fx_t           prod_r, quot_r;
  logic [SW-1:0] sd9_r;

  logic [63:0]   ma, mb;
  logic [65:0]   tot;
  logic          sat;
  logic [63:0]   acc;

  always_comb begin
    ma  = a1_r[63] ? 64'(-a1_r) : 64'(a1_r);
    mb  = b1_r[63] ? 64'(-b1_r) : 64'(b1_r);
    tot = {3'b0, hh3_r[30:0], 32'b0} + {2'b0, hl3_r} + {2'b0, lh3_r} + {34'b0, ll3_r};
    sat = (hh3_r[63:31] != '0) || (tot > 66'(FX_MAX));
    acc = sat ? 64'(FX_MAX) : tot[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      dv_r[0]  <= 1'b0;
    end else begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      dv_r[0]  <= v3_r;
    end
    a1_r      <= a;
    b1_r      <= b;
    sd1_r     <= in_side;
    ma2_r     <= ma;
    mb2_r     <= mb;
    n2_r      <= a1_r[63] ^ b1_r[63];
    sd2_r     <= sd1_r;
    hh3_r     <= 64'(ma2_r[63:32]) * 64'(mb2_r[63:32]);
    hl3_r     <= 64'(ma2_r[63:32]) * 64'(mb2_r[31:0]);
    lh3_r     <= 64'(ma2_r[31:0]) * 64'(mb2_r[63:32]);
    ll3_r     <= 32'((64'(ma2_r[31:0]) * 64'(mb2_r[31:0])) >> 32);
    n3_r      <= n2_r;
    sd3_r     <= sd2_r;
    dacc_r[0] <= acc;
    dq_r[0]   <= '0;
    drem_r[0] <= '0;
    dn_r[0]   <= n3_r;
    dsd_r[0]  <= sd3_r;
  end

  for (genvar i = 0; i < CHUNKS; i++) begin : g_div
    logic [VW-1:0] v;
    logic [PW-1:0] prd;
    logic [CW-1:0] q0;
    logic [VW-1:0] r0;
    logic          ge;

    always_comb begin
      v   = {drem_r[i], dacc_r[i][63-CW*i -: CW]};
      prd = PW'(v) * PW'(RECIP);
      q0  = prd[VW +: CW];
      r0  = v - VW'(VW'(q0) * VW'(DIVW));
      ge  = r0 >= VW'(DIVW);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else begin
        dv_r[i+1] <= dv_r[i];
      end
      dacc_r[i+1] <= dacc_r[i];
      dq_r[i+1]   <= {dq_r[i][63-CW:0], ge ? CW'(q0 + CW'(1)) : q0};
      drem_r[i+1] <= ge ? RW'(r0 - VW'(DIVW)) : r0[RW-1:0];
      dn_r[i+1]   <= dn_r[i];
      dsd_r[i+1]  <= dsd_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= dv_r[CHUNKS];
    end
    prod_r <= dn_r[CHUNKS] ? -fx_t'(dacc_r[CHUNKS]) : fx_t'(dacc_r[CHUNKS]);
    quot_r <= dn_r[CHUNKS] ? -fx_t'(dq_r[CHUNKS]) : fx_t'(dq_r[CHUNKS]);
    sd9_r  <= dsd_r[CHUNKS];
  end

  assign out_valid = v9_r;
  assign prod      = prod_r;
  assign quot      = quot_r;
  assign out_side  = sd9_r;

endmodule

// ----- hw/rtl/gamma_power_series_unit.sv -----
// Top level of the gamma power series unit: x raised to a programmable power.
//
//   port group   dir  handshake            payload
//   in_          in   start / busy         in_level_in [16:0]
//   out_         out  out_strobe           out_power_out [23:0], out_overflow_flag
//   cfg_         in   cfg_we               cfg_wdata [15:0]
//
// A transfer is taken in every cycle; busy is always low.
// The pipeline is the 32-step quotient for t, the chain of 9-stage multiply units
// and the 24-step reciprocal. Synchronous reset clears all valid bits and sets
// the exponent to 1.0. The receiver cannot stall, so results leave as they finish.
`include "gamma_power_series_unit_assert.svh"

module gamma_power_series_unit
  import gps_pkg::*;
#(
  parameter int LN_TERMS = 10,
  parameter int EXP_TERMS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [16:0]        in_level_in,
  output logic               out_strobe,
  output logic [23:0]        out_power_out,
  output logic               out_overflow_flag,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata
);

  localparam int NL = LN_TERMS - 1;
  localparam int NE = EXP_TERMS - 2;
  localparam int PIPE_LAT = 5 + T_BITS + Q_BITS + MUL_LAT * (NL + NE + 2);

  logic signed [15:0] exponent_r;

  logic        td_v_r   [0:T_BITS];
  logic [17:0] td_rem_r [0:T_BITS];
  logic [17:0] td_d_r   [0:T_BITS];
  logic [31:0] td_q_r   [0:T_BITS];
  logic        td_n_r   [0:T_BITS];
  logic        td_z_r   [0:T_BITS];

  logic        t_v_r;
  fx_t         t_r;
  logic        t_z_r;

  logic        ln_v   [0:NL];
  fx_t         ln_r   [0:NL];
  fx_t         ln_t2  [0:NL];
  fx_t         ln_sp  [0:NL];
  fx_t         ln_q   [0:NL];
  fx_t         ln_sum [0:NL];
  logic        ln_z   [0:NL];

  logic        dbl_v_r;
  fx_t         sum2_r;
  logic        dbl_z_r;

  fx_t         ya;
  fx_t         ypr;
  logic        ex_v  [0:NE];
  fx_t         ex_r  [0:NE];
  fx_t         ex_u  [0:NE];
  fx_t         ex_ep [0:NE];
  fx_t         ex_e  [0:NE];
  logic        ex_z  [0:NE];

  logic        qd_v_r    [0:Q_BITS];
  logic [63:0] qd_rem_r  [0:Q_BITS];
  logic [63:0] qd_e_r    [0:Q_BITS];
  logic [23:0] qd_q_r    [0:Q_BITS];
  logic        qd_div_r  [0:Q_BITS];
  logic [23:0] qd_pow_r  [0:Q_BITS];
  logic        qd_flag_r [0:Q_BITS];

  logic        out_strobe_r;
  logic [23:0] power_r;
  logic        flag_r;

  logic [16:0] lvl_mag;
  fx_t         e_fin;
  logic        e_big;
  logic [23:0] pow_sel;
  logic        flag_sel;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= EXP_RESET;
    end else if (cfg_we) begin
      exponent_r <= cfg_wdata;
    end
  end

  assign lvl_mag = in_level_in[16] ? {1'b0, in_level_in[15:0]} : 17'(17'h1_0000 - in_level_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_v_r[0] <= 1'b0;
    end else begin
      td_v_r[0] <= start && !busy;
    end
    td_rem_r[0] <= 18'(lvl_mag);
    td_d_r[0]   <= 18'(in_level_in) + 18'h1_0000;
    td_q_r[0]   <= '0;
    td_n_r[0]   <= !in_level_in[16];
    td_z_r[0]   <= in_level_in == '0;
  end

  for (genvar i = 0; i < T_BITS; i++) begin : g_tdiv
    logic [18:0] rs;
    logic        ge;

    always_comb begin
      rs = {td_rem_r[i], 1'b0};
      ge = rs >= {1'b0, td_d_r[i]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        td_v_r[i+1] <= 1'b0;
      end else begin
        td_v_r[i+1] <= td_v_r[i];
      end
      td_rem_r[i+1] <= ge ? 18'(rs - {1'b0, td_d_r[i]}) : rs[17:0];
      td_d_r[i+1]   <= td_d_r[i];
      td_q_r[i+1]   <= {td_q_r[i][30:0], ge};
      td_n_r[i+1]   <= td_n_r[i];
      td_z_r[i+1]   <= td_z_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else begin
      t_v_r <= td_v_r[T_BITS];
    end
    t_r   <= td_n_r[T_BITS] ? -fx_t'({32'b0, td_q_r[T_BITS]}) : fx_t'({32'b0, td_q_r[T_BITS]});
    t_z_r <= td_z_r[T_BITS];
  end

  gps_mul #(.DIV(1), .SW(65)) u_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (t_v_r),
    .a        (t_r),
    .b        (t_r),
    .in_side  ({t_r, t_z_r}),
    .out_valid(ln_v[0]),
    .prod     (ln_t2[0]),
    .quot     (),
    .out_side ({ln_r[0], ln_z[0]})
  );

  assign ln_sp[0] = '0;
  assign ln_q[0]  = ln_r[0];

  for (genvar j = 0; j <= NL; j++) begin : g_lnsum
    assign ln_sum[j] = sat_add(ln_sp[j], ln_q[j]);
  end

  for (genvar j = 0; j < NL; j++) begin : g_ln
    gps_mul #(.DIV(2 * j + 3), .SW(129)) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (ln_v[j]),
      .a        (ln_r[j]),
      .b        (ln_t2[j]),
      .in_side  ({ln_t2[j], ln_sum[j], ln_z[j]}),
      .out_valid(ln_v[j+1]),
      .prod     (ln_r[j+1]),
      .quot     (ln_q[j+1]),
      .out_side ({ln_t2[j+1], ln_sp[j+1], ln_z[j+1]})
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_v_r <= 1'b0;
    end else begin
      dbl_v_r <= ln_v[NL];
    end
    sum2_r  <= sat_add(ln_sum[NL], ln_sum[NL]);
    dbl_z_r <= ln_z[NL];
  end

  assign ya = {{28{exponent_r[15]}}, exponent_r, 20'b0};

  gps_mul #(.DIV(1), .SW(1)) u_ymul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dbl_v_r),
    .a        (ya),
    .b        (sum2_r),
    .in_side  (dbl_z_r),
    .out_valid(ex_v[0]),
    .prod     (ypr),
    .quot     (),
    .out_side (ex_z[0])
  );

  assign ex_u[0]  = -ypr;
  assign ex_r[0]  = ex_u[0];
  assign ex_ep[0] = FX_ONE;

  for (genvar j = 0; j <= NE; j++) begin : g_esum
    assign ex_e[j] = sat_add(ex_ep[j], ex_r[j]);
  end

  for (genvar j = 0; j < NE; j++) begin : g_exp
    gps_mul #(.DIV(j + 2), .SW(129)) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (ex_v[j]),
      .a        (ex_r[j]),
      .b        (ex_u[j]),
      .in_side  ({ex_u[j], ex_e[j], ex_z[j]}),
      .out_valid(ex_v[j+1]),
      .prod     (),
      .quot     (ex_r[j+1]),
      .out_side ({ex_u[j+1], ex_ep[j+1], ex_z[j+1]})
    );
  end

  always_comb begin
    e_fin = ex_e[NE];
    e_big = e_fin > E_SAT_LIMIT;
    priority if (ex_z[NE]) begin
      pow_sel  = (exponent_r == '0) ? OUT_ONE : '0;
      flag_sel = 1'b0;
    end else if (e_fin[63]) begin
      pow_sel  = '0;
      flag_sel = 1'b0;
    end else begin
      pow_sel  = OUT_MAX;
      flag_sel = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qd_v_r[0] <= 1'b0;
    end else begin
      qd_v_r[0] <= ex_v[NE];
    end
    qd_rem_r[0]  <= 64'd1 << Q_BITS;
    qd_e_r[0]    <= 64'(e_fin);
    qd_q_r[0]    <= '0;
    qd_div_r[0]  <= !ex_z[NE] && e_big;
    qd_pow_r[0]  <= pow_sel;
    qd_flag_r[0] <= flag_sel;
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_qdiv
    logic [63:0] rs;
    logic        ge;

    always_comb begin
      rs = {qd_rem_r[i][62:0], 1'b0};
      ge = rs >= qd_e_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qd_v_r[i+1] <= 1'b0;
      end else begin
        qd_v_r[i+1] <= qd_v_r[i];
      end
      qd_rem_r[i+1]  <= ge ? rs - qd_e_r[i] : rs;
      qd_e_r[i+1]    <= qd_e_r[i];
      qd_q_r[i+1]    <= {qd_q_r[i][22:0], ge};
      qd_div_r[i+1]  <= qd_div_r[i];
      qd_pow_r[i+1]  <= qd_pow_r[i];
      qd_flag_r[i+1] <= qd_flag_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= qd_v_r[Q_BITS];
    end
    power_r <= qd_div_r[Q_BITS] ? qd_q_r[Q_BITS] : qd_pow_r[Q_BITS];
    flag_r  <= qd_div_r[Q_BITS] ? 1'b0 : qd_flag_r[Q_BITS];
  end

  assign out_strobe        = out_strobe_r;
  assign out_power_out     = power_r;
  assign out_overflow_flag = flag_r;

  `GPS_ASSERT_DELAY(a_latency, start && !busy, PIPE_LAT, out_strobe)
  `GPS_ASSERT_IMPL(a_no_spurious, out_strobe, $past(start, PIPE_LAT))
  `GPS_ASSERT_IMPL(a_flag_max, out_strobe && out_overflow_flag, out_power_out == OUT_MAX)

endmodule
